[rtl/gtm_pkg.sv]
// Goertzel tone magnitude: shared types, widths and reset values.
// No dependencies; used by every other file of the block.
package gtm_pkg;

  localparam int WORD_BITS    = 32;
  localparam int REG_BITS     = 27;
  localparam int MAG_BITS     = 17;
  localparam int CFG_IDX_BITS = 2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [REG_BITS-1:0]  coef_t;
  typedef logic signed [MAG_BITS-1:0]  mag_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COEF = 2'd0,
    REG_COS  = 2'd1,
    REG_SIN  = 2'd2
  } cfg_idx_t;

  localparam coef_t COEF_RESET = 27'sd64070443;
  localparam coef_t COS_RESET  = 27'sd32035221;
  localparam coef_t SIN_RESET  = 27'sd9982376;

  typedef struct packed {
    coef_t coef;
    coef_t cos_coef;
    coef_t sin_coef;
  } cfg_t;

  // recurrence stage to magnitude stage
  typedef struct packed {
    word_t q0;
    word_t d2;
    logic  last;
  } rec_t;

endpackage

[rtl/gtm_if.sv]
// Goertzel tone magnitude: channel interfaces for sample, result and register writes.
// Depends on gtm_pkg.
interface gtm_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface gtm_out_if;
  logic          valid;
  logic          ready;
  gtm_pkg::mag_t tone_magnitude;
  logic          block_end;

  modport source (output valid, output tone_magnitude, output block_end, input ready);
  modport sink   (input valid, input tone_magnitude, input block_end, output ready);
endinterface

interface gtm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gtm_pkg::CFG_IDX_BITS-1:0] index;
  logic [gtm_pkg::REG_BITS-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/gtm_cfg_regs.sv]
// Goertzel tone magnitude: coefficient register file written over the cfg channel.
// Depends on gtm_pkg and gtm_cfg_if.
module gtm_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  gtm_cfg_if.sink         cfg_ch,
  output gtm_pkg::cfg_t   cfg
);

  gtm_pkg::coef_t coef_r;
  gtm_pkg::coef_t cos_r;
  gtm_pkg::coef_t sin_r;
  logic           wr;

  assign cfg_ch.ready = 1'b1;
  assign wr           = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= gtm_pkg::COEF_RESET;
      cos_r  <= gtm_pkg::COS_RESET;
      sin_r  <= gtm_pkg::SIN_RESET;
    end else if (wr) begin
      unique case (gtm_pkg::cfg_idx_t'(cfg_ch.index))
        gtm_pkg::REG_COEF: coef_r <= gtm_pkg::coef_t'(cfg_ch.data);
        gtm_pkg::REG_COS:  cos_r  <= gtm_pkg::coef_t'(cfg_ch.data);
        gtm_pkg::REG_SIN:  sin_r  <= gtm_pkg::coef_t'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  assign cfg.coef     = coef_r;
  assign cfg.cos_coef = cos_r;
  assign cfg.sin_coef = sin_r;

endmodule

[rtl/gtm_recurrence.sv]
// Goertzel tone magnitude: input register, block position counter and recurrence step.
// Depends on gtm_pkg and gtm_in_if.
module gtm_recurrence #(
  parameter int BLOCK_LENGTH  = 512,
  parameter int FRACTION_BITS = 25,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  gtm_in_if.sink         in_ch,
  input  gtm_pkg::cfg_t  cfg,
  output gtm_pkg::rec_t  rec,
  output logic           rec_valid,
  input  logic           rec_ready
);

  localparam int POS_W    = (BLOCK_LENGTH > 1) ? $clog2(BLOCK_LENGTH) : 1;
  localparam int SHIFT_UP = (FRACTION_BITS >= SAMPLE_BITS) ? FRACTION_BITS - SAMPLE_BITS : 0;
  localparam int SHIFT_DN = (FRACTION_BITS >= SAMPLE_BITS) ? 0 : SAMPLE_BITS - FRACTION_BITS;
  localparam int PROD_W   = gtm_pkg::REG_BITS + gtm_pkg::WORD_BITS;

  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic                   pos_last;
  logic                   in_xfer;

  logic                   s0_v_r, s0_v_nxt;
  logic [SAMPLE_BITS-1:0] s0_raw_r;
  logic                   s0_first_r;
  logic                   s0_last_r;
  logic                   s1_load;

  logic                   s1_v_r, s1_v_nxt;
  gtm_pkg::rec_t          s1_r;

  gtm_pkg::word_t         delay_one_r;
  gtm_pkg::word_t         delay_two_r;
  gtm_pkg::word_t         d1_eff, d2_eff, sample_w, q0;
  logic signed [PROD_W-1:0] prod, prod_sh;

  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign s1_load     = s0_v_r && (!s1_v_r || rec_ready);
  assign in_ch.ready = !s0_v_r || s1_load;

  assign pos_last = (pos_r == POS_W'(BLOCK_LENGTH - 1));
  assign pos_nxt  = pos_last ? '0 : pos_r + POS_W'(1);
  assign s0_v_nxt = in_xfer || (s0_v_r && !s1_load);
  assign s1_v_nxt = s1_load || (s1_v_r && !rec_ready);

  // delays restart at the first sample of a block
  always_comb begin
    sample_w = gtm_pkg::word_t'((gtm_pkg::WORD_BITS'(s0_raw_r) << SHIFT_UP) >> SHIFT_DN);
    d1_eff   = s0_first_r ? '0 : delay_one_r;
    d2_eff   = s0_first_r ? '0 : delay_two_r;
    prod     = cfg.coef * d1_eff;
    prod_sh  = prod >>> FRACTION_BITS;
    q0       = sample_w + prod_sh[gtm_pkg::WORD_BITS-1:0] - d2_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      delay_one_r <= '0;
      delay_two_r <= '0;
    end else begin
      s0_v_r <= s0_v_nxt;
      s1_v_r <= s1_v_nxt;
      if (in_xfer) begin
        pos_r <= pos_nxt;
      end
      if (s1_load) begin
        delay_one_r <= q0;
        delay_two_r <= d1_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s0_raw_r   <= in_ch.adc_sample;
      s0_first_r <= (pos_r == '0);
      s0_last_r  <= pos_last;
    end
    if (s1_load) begin
      s1_r.q0   <= q0;
      s1_r.d2   <= d1_eff;
      s1_r.last <= s0_last_r;
    end
  end

  assign rec       = s1_r;
  assign rec_valid = s1_v_r;

endmodule

[rtl/gtm_magnitude.sv]
// Goertzel tone magnitude: real/imaginary products, magnitude estimate, result register.
// Depends on gtm_pkg and gtm_out_if.
module gtm_magnitude #(
  parameter int FRACTION_BITS = 25,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  gtm_pkg::cfg_t  cfg,
  input  gtm_pkg::rec_t  rec,
  input  logic           rec_valid,
  output logic           rec_ready,
  gtm_out_if.source      out_ch
);

  localparam int SHIFT_UP = (FRACTION_BITS >= SAMPLE_BITS) ? FRACTION_BITS - SAMPLE_BITS : 0;
  localparam int SHIFT_DN = (FRACTION_BITS >= SAMPLE_BITS) ? 0 : SAMPLE_BITS - FRACTION_BITS;
  localparam int PROD_W   = gtm_pkg::REG_BITS + gtm_pkg::WORD_BITS;

  logic                     s2_load, s3_load;
  logic                     s2_v_r, s2_v_nxt;
  logic                     out_v_r, out_v_nxt;
  gtm_pkg::word_t           re_r, im_r;
  logic                     last2_r;
  gtm_pkg::mag_t            mag_r;
  logic                     last3_r;

  logic signed [PROD_W-1:0] pc, ps, pc_sh, ps_sh;
  gtm_pkg::word_t           re_nxt, im_nxt;
  gtm_pkg::word_t           ar, ai, mn, mag, res;

  assign s3_load   = s2_v_r && (!out_v_r || out_ch.ready);
  assign rec_ready = !s2_v_r || s3_load;
  assign s2_load   = rec_valid && rec_ready;
  assign s2_v_nxt  = s2_load || (s2_v_r && !s3_load);
  assign out_v_nxt = s3_load || (out_v_r && !out_ch.ready);

  always_comb begin
    pc     = cfg.cos_coef * rec.d2;
    ps     = cfg.sin_coef * rec.d2;
    pc_sh  = pc >>> FRACTION_BITS;
    ps_sh  = ps >>> FRACTION_BITS;
    re_nxt = rec.q0 - pc_sh[gtm_pkg::WORD_BITS-1:0];
    im_nxt = ps_sh[gtm_pkg::WORD_BITS-1:0];
  end

  // |a| + |b| - min/2; abs of the most negative word stays negative
  always_comb begin
    ar  = re_r[gtm_pkg::WORD_BITS-1] ? -re_r : re_r;
    ai  = im_r[gtm_pkg::WORD_BITS-1] ? -im_r : im_r;
    mn  = (ar < ai) ? ar : ai;
    mag = ar + ai - (mn >>> 1);
    res = (mag >>> SHIFT_UP) << SHIFT_DN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      re_r    <= re_nxt;
      im_r    <= im_nxt;
      last2_r <= rec.last;
    end
    if (s3_load) begin
      mag_r   <= res[gtm_pkg::MAG_BITS-1:0];
      last3_r <= last2_r;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.tone_magnitude = mag_r;
  assign out_ch.block_end      = last3_r;

endmodule

[rtl/goertzel_tone_magnitude.sv]
// Goertzel tone magnitude estimator, top level.
// Depends on gtm_pkg, gtm_if, gtm_cfg_regs, gtm_recurrence and gtm_magnitude.
//
// in_ch carries one converter sample per transfer; out_ch returns one result per
// sample: the scaled magnitude estimate and a flag on the last sample of each
// block of BLOCK_LENGTH samples. cfg_ch writes the 2cos, cos and sin
// coefficients (index 0, 1, 2; other indexes are ignored) and is always ready;
// write it only while no sample is in flight.
// A sample passes through four register stages (input, recurrence, products,
// result) before its result is presented.
// Throughput: one sample per cycle while out_ch takes results; the delay update
// is one 27x32 multiply and add per cycle. Each stage holds only while the stage
// after it is full and stalled, so in_ch stays ready while the pipeline has an
// empty slot, and is always ready while out_ch has no result waiting.
// Reset clears all stages, the delays and the block position and restores
// the coefficient reset values.
module goertzel_tone_magnitude #(
  parameter int BLOCK_LENGTH  = 512,
  parameter int FRACTION_BITS = 25,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  gtm_in_if.sink    in_ch,
  gtm_out_if.source out_ch,
  gtm_cfg_if.sink   cfg_ch
);

  gtm_pkg::cfg_t cfg;
  gtm_pkg::rec_t rec;
  logic          rec_valid;
  logic          rec_ready;

  gtm_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  gtm_recurrence #(
    .BLOCK_LENGTH  (BLOCK_LENGTH),
    .FRACTION_BITS (FRACTION_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_recurrence (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .rec       (rec),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready)
  );

  gtm_magnitude #(
    .FRACTION_BITS (FRACTION_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_magnitude (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .rec       (rec),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .out_ch    (out_ch)
  );

endmodule

[rtl/gtm_checker.sv]
// Goertzel tone magnitude: port-level assertions, bound to the top level.
// Depends on gtm_pkg and goertzel_tone_magnitude.
module gtm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input gtm_pkg::mag_t out_mag,
  input logic          out_last
);

  // output register empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with no result waiting, the pipeline always has room for a sample
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_mag) && $stable(out_last))
    else $error("result changed while stalled");

endmodule

bind goertzel_tone_magnitude gtm_checker u_gtm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_mag   (out_ch.tone_magnitude),
  .out_last  (out_ch.block_end)
);
